/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent on the same edge
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/tji_pkg.sv */
// ----------------------------------------------------------------------------
// tji_pkg
// types and constants of the tetrahedron jacobian inverse unit
// ----------------------------------------------------------------------------
package tji_pkg;

  localparam int CoordW    = 20;
  localparam int JW        = 21;
  localparam int ProdW     = 42;
  localparam int AdjW      = 43;
  localparam int NumW      = 42;
  localparam int DetW      = 64;
  localparam int DenW      = 63;
  localparam int QW        = 48;
  localparam int OutW      = 48;
  localparam int NumEnt    = 9;
  localparam int QuotShift = 42;
  localparam int DivSteps  = NumW + QuotShift;
  // j, products, adjugate, det products, det, divider steps, output
  localparam int Latency   = 5 + DivSteps + 1;

  localparam logic [QW-1:0] NegMag = {1'b1, {(QW-1){1'b0}}};
  localparam logic [QW-1:0] PosMax = {1'b0, {(QW-1){1'b1}}};

  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [NumW-1:0] num;
    logic [QW-1:0]   quo;
    logic            over;
    logic            neg;
  } lane_t;

  typedef struct packed {
    logic                   valid;
    logic [DenW-1:0]        den;
    logic signed [DetW-1:0] det;
    logic                   degen;
  } div_ctl_t;

endpackage

/* hdl/tetra_jacobian_inverse_unit.sv */
// ----------------------------------------------------------------------------
// tetra_jacobian_inverse_unit
// Takes the four vertices of a tetrahedron in Q10.10, gives the jacobian
// determinant (Q30) and its inverse (Q15.32, truncated, saturated).
// A new element may be started every clock cycle; busy is never raised.
// Each result appears for one cycle, with out_valid high. Most of the
// pipeline is the restoring divider: 84 quotient steps, one pipeline
// stage each, after five stages of multiply and add.
// The receiver cannot stall the pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tetra_jacobian_inverse_unit
  import tji_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [CoordW-1:0] in_v0_x,
  input  logic signed [CoordW-1:0] in_v0_y,
  input  logic signed [CoordW-1:0] in_v0_z,
  input  logic signed [CoordW-1:0] in_v1_x,
  input  logic signed [CoordW-1:0] in_v1_y,
  input  logic signed [CoordW-1:0] in_v1_z,
  input  logic signed [CoordW-1:0] in_v2_x,
  input  logic signed [CoordW-1:0] in_v2_y,
  input  logic signed [CoordW-1:0] in_v2_z,
  input  logic signed [CoordW-1:0] in_v3_x,
  input  logic signed [CoordW-1:0] in_v3_y,
  input  logic signed [CoordW-1:0] in_v3_z,
  output logic                   out_valid,
  output logic signed [OutW-1:0] out_inv_00,
  output logic signed [OutW-1:0] out_inv_01,
  output logic signed [OutW-1:0] out_inv_02,
  output logic signed [OutW-1:0] out_inv_10,
  output logic signed [OutW-1:0] out_inv_11,
  output logic signed [OutW-1:0] out_inv_12,
  output logic signed [OutW-1:0] out_inv_20,
  output logic signed [OutW-1:0] out_inv_21,
  output logic signed [OutW-1:0] out_inv_22,
  output logic signed [DetW-1:0] out_determinant,
  output logic                   out_degenerate
);

  logic                   v1_r, v2_r, v3_r, v4_r;
  logic signed [JW-1:0]   j1_r [3][3];
  logic signed [JW-1:0]   j2_r [3];
  logic signed [JW-1:0]   j3_r [3];
  logic signed [ProdW-1:0] pa_r [NumEnt];
  logic signed [ProdW-1:0] pb_r [NumEnt];
  logic signed [AdjW-1:0] adj3_r [NumEnt];
  logic signed [AdjW-1:0] adj4_r [NumEnt];
  logic signed [DetW-1:0] dp_r [3];

  div_ctl_t ctl_r [DivSteps+1];
  div_ctl_t ctl_nxt [DivSteps+1];
  lane_t    ln_r  [DivSteps+1][NumEnt];
  lane_t    ln_nxt [DivSteps+1][NumEnt];

  logic                   ov_r;
  logic signed [OutW-1:0] inv_r [NumEnt];
  logic signed [OutW-1:0] inv_nxt [NumEnt];
  logic signed [DetW-1:0] det_o_r;
  logic                   deg_o_r;

  logic signed [DetW-1:0] det_sum;
  logic                   acc;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // valid bits and divider control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
      for (int s = 0; s <= DivSteps; s++) ctl_r[s].valid <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      for (int s = 0; s <= DivSteps; s++) ctl_r[s] <= ctl_nxt[s];
      ov_r <= ctl_r[DivSteps].valid;
    end
  end

  // jacobian, adjugate products, adjugate, det products
  always_ff @(posedge clk) begin
    j1_r[0][0] <= JW'(in_v0_x) - JW'(in_v3_x);
    j1_r[0][1] <= JW'(in_v0_y) - JW'(in_v3_y);
    j1_r[0][2] <= JW'(in_v0_z) - JW'(in_v3_z);
    j1_r[1][0] <= JW'(in_v1_x) - JW'(in_v3_x);
    j1_r[1][1] <= JW'(in_v1_y) - JW'(in_v3_y);
    j1_r[1][2] <= JW'(in_v1_z) - JW'(in_v3_z);
    j1_r[2][0] <= JW'(in_v2_x) - JW'(in_v3_x);
    j1_r[2][1] <= JW'(in_v2_y) - JW'(in_v3_y);
    j1_r[2][2] <= JW'(in_v2_z) - JW'(in_v3_z);

    // entry index is row * 3 + column of the adjugate
    pa_r[0] <= ProdW'(j1_r[1][1] * j1_r[2][2]);
    pb_r[0] <= ProdW'(j1_r[1][2] * j1_r[2][1]);
    pa_r[1] <= ProdW'(j1_r[0][2] * j1_r[2][1]);
    pb_r[1] <= ProdW'(j1_r[0][1] * j1_r[2][2]);
    pa_r[2] <= ProdW'(j1_r[0][1] * j1_r[1][2]);
    pb_r[2] <= ProdW'(j1_r[0][2] * j1_r[1][1]);
    pa_r[3] <= ProdW'(j1_r[1][2] * j1_r[2][0]);
    pb_r[3] <= ProdW'(j1_r[1][0] * j1_r[2][2]);
    pa_r[4] <= ProdW'(j1_r[0][0] * j1_r[2][2]);
    pb_r[4] <= ProdW'(j1_r[0][2] * j1_r[2][0]);
    pa_r[5] <= ProdW'(j1_r[0][2] * j1_r[1][0]);
    pb_r[5] <= ProdW'(j1_r[0][0] * j1_r[1][2]);
    pa_r[6] <= ProdW'(j1_r[1][0] * j1_r[2][1]);
    pb_r[6] <= ProdW'(j1_r[1][1] * j1_r[2][0]);
    pa_r[7] <= ProdW'(j1_r[0][1] * j1_r[2][0]);
    pb_r[7] <= ProdW'(j1_r[0][0] * j1_r[2][1]);
    pa_r[8] <= ProdW'(j1_r[0][0] * j1_r[1][1]);
    pb_r[8] <= ProdW'(j1_r[0][1] * j1_r[1][0]);
    for (int c = 0; c < 3; c++) j2_r[c] <= j1_r[0][c];

    for (int e = 0; e < NumEnt; e++) adj3_r[e] <= AdjW'(pa_r[e]) - AdjW'(pb_r[e]);
    j3_r <= j2_r;

    dp_r[0] <= DetW'(j3_r[0]) * DetW'(adj3_r[0]);
    dp_r[1] <= DetW'(j3_r[1]) * DetW'(adj3_r[3]);
    dp_r[2] <= DetW'(j3_r[2]) * DetW'(adj3_r[6]);
    adj4_r <= adj3_r;
  end

  assign det_sum = dp_r[0] + dp_r[1] + dp_r[2];

  // divider head and one restoring step per stage
  always_comb begin
    logic [DetW-1:0]  dmag;
    logic [AdjW-1:0]  amag;
    logic [DenW:0]    rs;
    logic             sub;
    logic [QW:0]      qs;
    dmag = det_sum[DetW-1] ? DetW'(-det_sum) : DetW'(det_sum);
    ctl_nxt[0].valid = v4_r;
    ctl_nxt[0].den   = dmag[DenW-1:0];
    ctl_nxt[0].det   = det_sum;
    ctl_nxt[0].degen = (det_sum == '0);
    for (int e = 0; e < NumEnt; e++) begin
      amag = adj4_r[e][AdjW-1] ? AdjW'(-adj4_r[e]) : AdjW'(adj4_r[e]);
      ln_nxt[0][e].rem  = '0;
      ln_nxt[0][e].num  = amag[NumW-1:0];
      ln_nxt[0][e].quo  = '0;
      ln_nxt[0][e].over = 1'b0;
      ln_nxt[0][e].neg  = adj4_r[e][AdjW-1] ^ det_sum[DetW-1];
    end
    for (int s = 0; s < DivSteps; s++) begin
      ctl_nxt[s+1] = ctl_r[s];
      for (int e = 0; e < NumEnt; e++) begin
        ln_nxt[s+1][e] = ln_r[s][e];
        // numerator bits enter msb first, zeros after them
        rs  = {ln_r[s][e].rem, (s < NumW) ? ln_r[s][e].num[NumW-1] : 1'b0};
        sub = (rs >= {1'b0, ctl_r[s].den});
        ln_nxt[s+1][e].rem = sub ? DenW'(rs - {1'b0, ctl_r[s].den}) : DenW'(rs);
        ln_nxt[s+1][e].num = {ln_r[s][e].num[NumW-2:0], 1'b0};
        qs = {ln_r[s][e].quo, sub};
        if (qs > {1'b0, NegMag}) begin
          ln_nxt[s+1][e].over = 1'b1;
          ln_nxt[s+1][e].quo  = NegMag + QW'(1);
        end else begin
          ln_nxt[s+1][e].quo  = qs[QW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s <= DivSteps; s++) begin
      for (int e = 0; e < NumEnt; e++) ln_r[s][e] <= ln_nxt[s][e];
    end
  end

  // sign, saturation and degenerate zeroing
  always_comb begin
    lane_t l;
    for (int e = 0; e < NumEnt; e++) begin
      l = ln_r[DivSteps][e];
      if (ctl_r[DivSteps].degen) begin
        inv_nxt[e] = '0;
      end else if (l.neg) begin
        inv_nxt[e] = (l.over || l.quo > NegMag) ? OutW'(NegMag) : OutW'(-l.quo);
      end else begin
        inv_nxt[e] = (l.over || l.quo > PosMax) ? OutW'(PosMax) : OutW'(l.quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    inv_r   <= inv_nxt;
    det_o_r <= ctl_r[DivSteps].det;
    deg_o_r <= ctl_r[DivSteps].degen;
  end

  assign out_valid       = ov_r;
  assign out_inv_00      = inv_r[0];
  assign out_inv_01      = inv_r[1];
  assign out_inv_02      = inv_r[2];
  assign out_inv_10      = inv_r[3];
  assign out_inv_11      = inv_r[4];
  assign out_inv_12      = inv_r[5];
  assign out_inv_20      = inv_r[6];
  assign out_inv_21      = inv_r[7];
  assign out_inv_22      = inv_r[8];
  assign out_determinant = det_o_r;
  assign out_degenerate  = deg_o_r;

  `ASSERT_IMPLIES(a_degen_det, clk, rst_n, out_valid && out_degenerate,
                  out_determinant == '0 && out_inv_00 == '0 && out_inv_22 == '0)
  `ASSERT_IMPLIES(a_nondegen_det, clk, rst_n, out_valid && !out_degenerate,
                  out_determinant != '0)
  `ASSERT_ALWAYS(a_latency, clk, rst_n,
                 ctl_r[DivSteps].valid == $past(acc, Latency - 1))

endmodule
